/* hdl/gtp_pkg.sv */
package gtp_pkg;

    localparam int DEFAULT_MAX_COLUMNS = 1048576;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    localparam logic [1:0] CODE_ZERO = 2'd0;
    localparam logic [1:0] CODE_ONE  = 2'd2;
    localparam logic [1:0] CODE_TWO  = 2'd3;
    localparam logic [1:0] CODE_NINE = 2'd1;

    localparam logic [2:0] CODES_PER_BYTE = 3'd4;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_INVALID  = 2'd1,
        ST_MISMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_DIGIT   = 2'd0,
        KIND_NEWLINE = 2'd1,
        KIND_OTHER   = 2'd2
    } t_char_kind;

    typedef struct packed {
        t_char_kind kind;
        logic [1:0] code;
    } t_char_info;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_result;

endpackage

/* hdl/gtp_decode.sv */
module gtp_decode
    import gtp_pkg::*;
(
    input  logic [7:0] i_char,
    output t_char_info o_info
);

    always_comb begin
        o_info.kind = KIND_DIGIT;
        o_info.code = CODE_ZERO;
        unique case (i_char)
            CHAR_ZERO:    o_info.code = CODE_ZERO;
            CHAR_ONE:     o_info.code = CODE_ONE;
            CHAR_TWO:     o_info.code = CODE_TWO;
            CHAR_NINE:    o_info.code = CODE_NINE;
            CHAR_NEWLINE: o_info.kind = KIND_NEWLINE;
            default:      o_info.kind = KIND_OTHER;
        endcase
    end

endmodule

/* hdl/gtp_pack.sv */
module gtp_pack
    import gtp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_char_info i_info,
    output t_result    o_result
);

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam logic [CW-1:0] MAX_COLS = CW'(MAX_COLUMNS);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_expected, n_expected;
    logic          r_first, n_first;
    logic [7:0]    r_acc, n_acc;
    logic [2:0]    r_group, n_group;
    logic          r_err, n_err;

    always_comb begin
        n_cnt      = r_cnt;
        n_expected = r_expected;
        n_first    = r_first;
        n_acc      = r_acc;
        n_group    = r_group;
        n_err      = r_err;
        o_result   = '{valid: 1'b0, data: 8'd0, last: 1'b0, status: ST_DATA};
        if (!r_err) begin
            unique case (i_info.kind)
                KIND_NEWLINE: begin
                    if (!r_first && (r_cnt != r_expected)) begin
                        n_err           = 1'b1;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_MISMATCH;
                    end else begin
                        if (r_first) begin
                            n_expected = r_cnt;
                            n_first    = 1'b0;
                        end
                        if (r_group != 3'd0) begin
                            o_result.valid = 1'b1;
                            o_result.data  = r_acc;
                            o_result.last  = 1'b1;
                        end
                    end
                    n_acc   = 8'd0;
                    n_group = 3'd0;
                    n_cnt   = '0;
                end
                KIND_DIGIT: begin
                    if ((r_cnt >= MAX_COLS) || (!r_first && (r_cnt >= r_expected))) begin
                        n_err           = 1'b1;
                        o_result.valid  = 1'b1;
                        o_result.status = ST_MISMATCH;
                        n_acc           = 8'd0;
                        n_group         = 3'd0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        if (r_group >= CODES_PER_BYTE) begin
                            o_result.valid = 1'b1;
                            o_result.data  = r_acc;
                            n_acc          = {6'd0, i_info.code};
                            n_group        = 3'd1;
                        end else begin
                            n_acc   = r_acc | ({6'd0, i_info.code} << {r_group[1:0], 1'b0});
                            n_group = r_group + 3'd1;
                        end
                    end
                end
                default: begin
                    n_err           = 1'b1;
                    o_result.valid  = 1'b1;
                    o_result.status = ST_INVALID;
                    n_acc           = 8'd0;
                    n_group         = 3'd0;
                end
            endcase
        end
        if (!i_en) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_expected <= '0;
            r_first    <= 1'b1;
            r_acc      <= 8'd0;
            r_group    <= 3'd0;
            r_err      <= 1'b0;
        end else if (i_en) begin
            r_cnt      <= n_cnt;
            r_expected <= n_expected;
            r_first    <= n_first;
            r_acc      <= n_acc;
            r_group    <= n_group;
            r_err      <= n_err;
        end
    end

endmodule

/* hdl/genotype_text_to_2bit_packer_core.sv */
// Packs a genotype text stream, one character per word, into bytes of four
// 2-bit codes ('0'->0, '1'->2, '2'->3, '9'->1, first column in bits 1:0);
// each newline-ended row is padded to a whole byte, and a row's last byte
// comes out with tlast set when its newline arrives. The first row fixes the
// column count; a later row that differs, or a row longer than MAX_COLUMNS,
// gives one word with tuser = 2, and any other character gives tuser = 1.
// Error words carry zero data, and after an error the block swallows every
// character until reset. One character is taken every clock cycle; a word
// leaves through an input register and an output register, and only a stalled
// output slows the input.
module genotype_text_to_2bit_packer_core
    import gtp_pkg::*;
#(
    parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // text_char[7:0]
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // packed_byte[7:0]
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser    // status[1:0]
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic [1:0] r_out_status;
    logic       advance;
    t_char_info info;
    t_result    result;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
    end

    gtp_decode u_decode (
        .i_char (r_in_char),
        .o_info (info)
    );

    gtp_pack #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_info   (info),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out_data   <= result.data;
            r_out_last   <= result.last;
            r_out_status <= result.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

endmodule

/* test/tb_genotype_text_to_2bit_packer_core.sv */
`timescale 1ns / 1ps

module tb_genotype_text_to_2bit_packer_core;
    import gtp_pkg::*;

    localparam int TB_MAX_COLUMNS = 12;
    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD = 200;
    localparam int PHASE_ITEMS = 380;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'h0d;

    typedef enum int {
        FAULT_BAD_CHAR,
        FAULT_LONG_ROW,
        FAULT_SHORT_ROW
    } t_fault_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_packed_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // text_char[7:0]
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // packed_byte[7:0]
    logic       o_m_tlast;
    logic [1:0] o_m_tuser;           // status[1:0]

    t_packed_word expected_words[$];
    int n_mismatches = 0;
    int n_sent = 0;
    int stuck_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int row_width = 1;

    // predictor state
    logic [20:0] col_cnt = '0;
    logic [20:0] exp_cols = '0;
    logic        first_row = 1'b1;
    logic [7:0]  acc = '0;
    logic [2:0]  n_codes = '0;
    logic        err_seen = 1'b0;

    genotype_text_to_2bit_packer_core #(
        .MAX_COLUMNS(TB_MAX_COLUMNS)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic push_word(input logic [7:0] data, input logic last, input t_status status);
        t_packed_word w;
        w.data = data;
        w.last = last;
        w.status = status;
        expected_words.push_back(w);
    endtask

    task automatic record_error(input t_status status);
        err_seen = 1'b1;
        acc = '0;
        n_codes = '0;
        push_word(8'h00, 1'b0, status);
    endtask

    task automatic pack_char(input logic [7:0] c);
        logic [1:0] code;
        logic       is_digit;
        if (err_seen) return;
        if (c == CHAR_NEWLINE) begin
            if (first_row) begin
                exp_cols = col_cnt;
                first_row = 1'b0;
            end else if (col_cnt != exp_cols) begin
                record_error(ST_MISMATCH);
                return;
            end
            if (n_codes != 0) push_word(acc, 1'b1, ST_DATA);
            acc = '0;
            n_codes = '0;
            col_cnt = '0;
            return;
        end
        is_digit = 1'b1;
        code = CODE_ZERO;
        case (c)
            CHAR_ZERO: code = CODE_ZERO;
            CHAR_ONE:  code = CODE_ONE;
            CHAR_TWO:  code = CODE_TWO;
            CHAR_NINE: code = CODE_NINE;
            default:   is_digit = 1'b0;
        endcase
        if (!is_digit) begin
            record_error(ST_INVALID);
            return;
        end
        if (col_cnt >= TB_MAX_COLUMNS || (!first_row && col_cnt >= exp_cols)) begin
            record_error(ST_MISMATCH);
            return;
        end
        col_cnt = col_cnt + 1'b1;
        if (n_codes == CODES_PER_BYTE) begin
            push_word(acc, 1'b0, ST_DATA);
            acc = {6'b0, code};
            n_codes = 3'd1;
        end else begin
            acc[2*n_codes +: 2] = code;
            n_codes = n_codes + 1'b1;
        end
    endtask

    function automatic logic [7:0] digit_char(input int sel);
        case (sel)
            0:       return CHAR_ZERO;
            1:       return CHAR_ONE;
            2:       return CHAR_TWO;
            default: return CHAR_NINE;
        endcase
    endfunction

    // entered and left at a falling edge; tvalid is left high after each word and drops only for idle gaps
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        do @(posedge i_clk); while (!o_s_tready);
        pack_char(c);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_row(input int n_digits);
        repeat (n_digits) send_char(digit_char($urandom_range(0, 3)));
        send_char(CHAR_NEWLINE);
    endtask

    // receiver
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_packed_word w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_words.size() == 0) begin
                if (n_mismatches < 10)
                    $display("%0t: unexpected word data %h last %b status %0d",
                             $realtime, o_m_tdata, o_m_tlast, o_m_tuser);
                n_mismatches++;
            end else begin
                w = expected_words.pop_front();
                if (o_m_tdata !== w.data || o_m_tlast !== w.last || o_m_tuser !== w.status) begin
                    if (n_mismatches < 10)
                        $display("%0t: word mismatch exp data %h last %b status %0d, got data %h last %b status %0d",
                                 $realtime, w.data, w.last, w.status,
                                 o_m_tdata, o_m_tlast, o_m_tuser);
                    n_mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic test_sender_pause();
        i_s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // first row fixes the width; its digits cycle through 0, 1, 2, 9 by column
    task automatic test_first_row();
        case ($urandom_range(0, 3))
            0:       row_width = TB_MAX_COLUMNS;
            1:       row_width = 1;
            default: row_width = $urandom_range(2, TB_MAX_COLUMNS - 1);
        endcase
        for (int i = 0; i < row_width; i++) send_char(digit_char(i % 4));
        send_char(CHAR_NEWLINE);
        repeat (row_width) send_char(CHAR_TWO);
        send_char(CHAR_NEWLINE);
    endtask

    task automatic test_random_rows(input int idle_pct, input int stall_pct);
        int start;
        start = n_sent;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        while (n_sent - start < PHASE_ITEMS) send_row(row_width);
    endtask

    task automatic test_output_hold_off();
        int start;
        start = n_sent;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_cycles <= LONG_HOLD;
        while (n_sent - start < 60) send_row(row_width);
    endtask

    // one fault latches for the rest of the run, so it goes last
    task automatic test_fault_and_lockout();
        t_fault_kind kind;
        int          cut;
        logic [7:0]  bad;
        send_idle_pct = 12;
        recv_stall_pct <= 12;
        kind = t_fault_kind'($urandom_range(0, 2));
        case (kind)
            FAULT_BAD_CHAR: begin
                cut = $urandom_range(0, row_width);
                repeat (cut) send_char(digit_char($urandom_range(0, 3)));
                case ($urandom_range(0, 2))
                    0: bad = CHAR_SPACE;
                    1: bad = CHAR_CR;
                    default: begin
                        bad = 8'($urandom_range(0, 255));
                        while (bad == CHAR_ZERO || bad == CHAR_ONE || bad == CHAR_TWO ||
                               bad == CHAR_NINE || bad == CHAR_NEWLINE)
                            bad = 8'($urandom_range(0, 255));
                    end
                endcase
                send_char(bad);
            end
            FAULT_LONG_ROW: begin
                repeat (row_width + 1) send_char(digit_char($urandom_range(0, 3)));
            end
            default: begin
                cut = $urandom_range(0, row_width - 1);
                repeat (cut) send_char(digit_char($urandom_range(0, 3)));
                send_char(CHAR_NEWLINE);
            end
        endcase
        // everything after the fault is swallowed
        for (int v = 0; v < 256; v++) send_char(v[7:0]);
        repeat (64) send_char(8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_row();
        test_sender_pause();
        test_random_rows(0, 0);
        test_sender_pause();
        test_random_rows(53, 0);
        test_sender_pause();
        test_random_rows(0, 53);
        test_sender_pause();
        test_random_rows(12, 12);
        test_sender_pause();
        test_output_hold_off();
        test_sender_pause();
        test_fault_and_lockout();
        test_sender_pause();
        repeat (10) @(posedge i_clk);

        if (n_mismatches == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/gtp_pkg.sv
hdl/gtp_decode.sv
hdl/gtp_pack.sv
hdl/genotype_text_to_2bit_packer_core.sv
test/tb_genotype_text_to_2bit_packer_core.sv
